// ----- src/gbts_pkg.sv -----
// ----------------------------------------------------------------------------
// gbts_pkg
// Shared types and constants for the gap buffer text store: capacity, field
// widths, operation codes and status codes.
// ----------------------------------------------------------------------------
package gbts_pkg;

  // Fixed capacity of the text memory in bytes.
  localparam int CAPACITY = 4096;
  localparam int ADDR_W   = $clog2(CAPACITY);

  // Field widths of the request and result channels.
  localparam int OPCODE_W = 3;
  localparam int BYTE_W   = 8;
  localparam int POS_W    = 13;
  localparam int STATUS_W = 2;

  localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT     = 3'd0,
    OP_DEL_BEFORE = 3'd1,
    OP_DEL_AFTER  = 3'd2,
    OP_MOVE       = 3'd3,
    OP_READ       = 3'd4
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

endpackage

// ----- src/gbts_ram.sv -----
// ----------------------------------------------------------------------------
// gbts_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. A read and a write of the same entry in the same cycle
// return the old contents.
// ----------------------------------------------------------------------------
module gbts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/gap_buffer_text_store_core.sv -----
// ----------------------------------------------------------------------------
// gap_buffer_text_store_core
// Fixed-capacity gap buffer for editor text, with the bytes held in one
// synchronous RAM and the gap bounds and length held in registers.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake               Payload
//   request   in         in_valid_i / in_stall_o  opcode_i, data_byte_i, position_i
//   result    out        out_valid_o / out_stall_i
//                                                 data_out_o, length_o, cursor_o,
//                                                 status_o
//
// An insert, a refused operation, a move to the current cursor and an unused
// opcode need no RAM read: the result is registered at the edge that accepts
// the request if the output register is free. Deletes and reads pass through
// S_RDATA to wait for the registered read data of the text RAM. A move runs in
// S_SHIFT: one byte crosses the gap per cycle through the RAM's read and write
// ports; the first step only issues a read and the last only drains a write.
// Reset empties the text (gap over the whole memory) and clears the control
// flags; the RAM is not cleared, since no byte is read before it is written.
// A stalled result waits in the output register; the next request is still
// taken, and its result is parked until the output register frees up.
//
module gap_buffer_text_store_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [gbts_pkg::OPCODE_W-1:0] opcode_i,
  input  logic [gbts_pkg::BYTE_W-1:0]   data_byte_i,
  input  logic [gbts_pkg::POS_W-1:0]    position_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [gbts_pkg::BYTE_W-1:0]   data_out_o,
  output logic [gbts_pkg::POS_W-1:0]    length_o,
  output logic [gbts_pkg::POS_W-1:0]    cursor_o,
  output logic [gbts_pkg::STATUS_W-1:0] status_o
);

  import gbts_pkg::*;

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;  // ready for a request
  localparam logic [1:0] S_RDATA = 2'd1;  // read data arrives from the RAM
  localparam logic [1:0] S_SHIFT = 2'd2;  // moving bytes across the gap
  localparam logic [1:0] S_HOLD  = 2'd3;  // result parked, output busy

  logic [1:0]        state_q, state_d;
  logic [POS_W-1:0]  gs_q, gs_d;        // gap start, also the cursor
  logic [POS_W-1:0]  ge_q, ge_d;        // gap end
  logic [POS_W-1:0]  len_q, len_d;      // content length
  logic [POS_W-1:0]  cnt_q, cnt_d;      // bytes still to move
  logic              left_q, left_d;    // move direction: towards the start
  logic              wb_valid_q, wb_valid_d;
  logic [ADDR_W-1:0] wb_addr_q, wb_addr_d;
  logic [BYTE_W-1:0] data_q, data_d;    // parked result byte
  status_e           status_q, status_d;

  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_data_q, out_data_d;
  logic [POS_W-1:0]  out_len_q, out_len_d;
  logic [POS_W-1:0]  out_cur_q, out_cur_d;
  status_e           out_status_q, out_status_d;

  // RAM port signals.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  opcode_e           op;
  logic [POS_W-1:0]  gap;
  logic [POS_W-1:0]  dest;
  logic [POS_W-1:0]  rd_idx;
  logic              out_free;
  logic              finish;
  logic [BYTE_W-1:0] fin_data;
  status_e           fin_status;
  logic              push;
  logic [BYTE_W-1:0] push_data;
  status_e           push_status;

  assign op       = opcode_e'(opcode_i);
  assign gap      = ge_q - gs_q;
  // A move past the end lands at the end of the content.
  assign dest     = (position_i > len_q) ? len_q : position_i;
  // A logical position at or beyond the cursor lies past the gap.
  assign rd_idx   = (position_i < gs_q) ? position_i : position_i + gap;
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    gs_d        = gs_q;
    ge_d        = ge_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    left_d      = left_q;
    wb_valid_d  = 1'b0;
    wb_addr_d   = wb_addr_q;
    data_d      = data_q;
    status_d    = status_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    finish      = 1'b0;
    fin_data    = '0;
    fin_status  = STAT_OK;
    push        = 1'b0;
    push_data   = '0;
    push_status = STAT_OK;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (op)
            OP_INSERT: begin
              finish = 1'b1;
              if (gs_q == ge_q) begin
                fin_status = STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(gs_q);
                ram_wdata = data_byte_i;
                gs_d      = gs_q + POS_W'(1);
                len_d     = len_q + POS_W'(1);
              end
            end
            OP_DEL_BEFORE: begin
              if (gs_q == '0) begin
                finish     = 1'b1;
                fin_status = STAT_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = ADDR_W'(gs_q - POS_W'(1));
                gs_d      = gs_q - POS_W'(1);
                len_d     = len_q - POS_W'(1);
                state_d   = S_RDATA;
              end
            end
            OP_DEL_AFTER: begin
              if (ge_q >= CAP_POS) begin
                finish     = 1'b1;
                fin_status = STAT_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = ADDR_W'(ge_q);
                ge_d      = ge_q + POS_W'(1);
                len_d     = len_q - POS_W'(1);
                state_d   = S_RDATA;
              end
            end
            OP_MOVE: begin
              if (dest < gs_q) begin
                cnt_d   = gs_q - dest;
                left_d  = 1'b1;
                state_d = S_SHIFT;
              end else if (dest > gs_q) begin
                cnt_d   = dest - gs_q;
                left_d  = 1'b0;
                state_d = S_SHIFT;
              end else begin
                finish = 1'b1;
              end
            end
            OP_READ: begin
              if (position_i >= len_q) begin
                finish     = 1'b1;
                fin_status = STAT_RANGE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = ADDR_W'(rd_idx);
                state_d   = S_RDATA;
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end

      S_RDATA: begin
        finish   = 1'b1;
        fin_data = ram_rdata;
      end

      S_SHIFT: begin
        // Write back the byte fetched in the previous cycle.
        if (wb_valid_q) begin
          ram_we    = 1'b1;
          ram_waddr = wb_addr_q;
          ram_wdata = ram_rdata;
        end
        if (cnt_q != '0) begin
          ram_re     = 1'b1;
          wb_valid_d = 1'b1;
          cnt_d      = cnt_q - POS_W'(1);
          if (left_q) begin
            ram_raddr = ADDR_W'(gs_q - POS_W'(1));
            wb_addr_d = ADDR_W'(ge_q - POS_W'(1));
            gs_d      = gs_q - POS_W'(1);
            ge_d      = ge_q - POS_W'(1);
          end else begin
            ram_raddr = ADDR_W'(ge_q);
            wb_addr_d = ADDR_W'(gs_q);
            gs_d      = gs_q + POS_W'(1);
            ge_d      = ge_q + POS_W'(1);
          end
        end else begin
          finish = 1'b1;
        end
      end

      S_HOLD: begin
        if (out_free) begin
          push        = 1'b1;
          push_data   = data_q;
          push_status = status_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A finished request goes straight to the output register when it is
    // free, and is parked otherwise.
    if (finish) begin
      if (out_free) begin
        push        = 1'b1;
        push_data   = fin_data;
        push_status = fin_status;
        state_d     = S_IDLE;
      end else begin
        data_d   = fin_data;
        status_d = fin_status;
        state_d  = S_HOLD;
      end
    end
  end

  // Output register. Length and cursor always show the state after the
  // request, which the next-state values carry in every case.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    out_len_d    = out_len_q;
    out_cur_d    = out_cur_q;
    out_status_d = out_status_q;
    if (push) begin
      out_valid_d  = 1'b1;
      out_data_d   = push_data;
      out_len_d    = len_d;
      out_cur_d    = gs_d;
      out_status_d = push_status;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gs_q        <= '0;
      ge_q        <= CAP_POS;
      len_q       <= '0;
      cnt_q       <= '0;
      left_q      <= 1'b0;
      wb_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gs_q        <= gs_d;
      ge_q        <= ge_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      left_q      <= left_d;
      wb_valid_q  <= wb_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wb_addr_q    <= wb_addr_d;
    data_q       <= data_d;
    status_q     <= status_d;
    out_data_q   <= out_data_d;
    out_len_q    <= out_len_d;
    out_cur_q    <= out_cur_d;
    out_status_q <= out_status_d;
  end

  gbts_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (CAPACITY)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_data_q;
  assign length_o    = out_len_q;
  assign cursor_o    = out_cur_q;
  assign status_o    = out_status_q;

endmodule

// ----- src/gbts_core_checker.sv -----
// ----------------------------------------------------------------------------
// gbts_core_checker
// Port-level checks for the gap buffer text store, bound to the top level.
// ----------------------------------------------------------------------------
module gbts_core_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [gbts_pkg::OPCODE_W-1:0] opcode_i,
  input logic [gbts_pkg::BYTE_W-1:0]   data_byte_i,
  input logic [gbts_pkg::POS_W-1:0]    position_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [gbts_pkg::BYTE_W-1:0]   data_out_o,
  input logic [gbts_pkg::POS_W-1:0]    length_o,
  input logic [gbts_pkg::POS_W-1:0]    cursor_o,
  input logic [gbts_pkg::STATUS_W-1:0] status_o
);

  import gbts_pkg::*;

  // A stalled request stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(opcode_i)
      && $stable(data_byte_i) && $stable(position_i))
    else $error("request changed while stalled");

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(data_out_o)
      && $stable(length_o) && $stable(cursor_o) && $stable(status_o))
    else $error("result changed while stalled");

  // A refused operation returns no byte.
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_OK) |-> data_out_o == '0)
    else $error("refused request returned a byte");

  // The cursor never lies beyond the content.
  a_cursor_in_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cursor_o <= length_o) && (length_o <= CAP_POS))
    else $error("cursor or length out of range");

  // An insert is only dropped when the buffer is full.
  a_full_only_at_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_FULL) |-> length_o == CAP_POS)
    else $error("insert dropped below capacity");

endmodule

bind gap_buffer_text_store_core gbts_core_checker u_gbts_core_checker (.*);
